// ===== src/alpn_sel_pkg.sv =====
// alpn_sel_pkg: types, constants and name tables for the ALPN list selector
// no dependencies; used by the channel interfaces and the top level
`default_nettype none

package alpn_sel_pkg;

    // byte offset counter width and saturation value
    localparam int unsigned CNT_W = 17;
    localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

    // protocol name lengths
    localparam logic [3:0] H3_LEN = 4'd2;
    localparam logic [3:0] HQ_LEN = 4'd10;

    typedef logic [7:0] byte_t;
    typedef logic [1:0] choice_t;

    // choice codes
    localparam choice_t CHOICE_NONE = 2'd0;
    localparam choice_t CHOICE_H3   = 2'd1;
    localparam choice_t CHOICE_HQ   = 2'd2;

    // expected byte of "h3" at a name position
    function automatic byte_t h3_byte(input logic [3:0] idx);
        byte_t val;
        unique case (idx)
            4'd0:    val = 8'h68;
            4'd1:    val = 8'h33;
            default: val = 8'h00;
        endcase
        return val;
    endfunction

    // expected byte of "hq-interop" at a name position
    function automatic byte_t hq_byte(input logic [3:0] idx);
        byte_t val;
        unique case (idx)
            4'd0:    val = 8'h68;
            4'd1:    val = 8'h71;
            4'd2:    val = 8'h2d;
            4'd3:    val = 8'h69;
            4'd4:    val = 8'h6e;
            4'd5:    val = 8'h74;
            4'd6:    val = 8'h65;
            4'd7:    val = 8'h72;
            4'd8:    val = 8'h6f;
            4'd9:    val = 8'h70;
            default: val = 8'h00;
        endcase
        return val;
    endfunction

endpackage

`default_nettype wire

// ===== src/alpn_sel_if.sv =====
// alpn_sel_if: valid/ready channel interfaces for extension bytes and choices
// depends on alpn_sel_pkg for payload types
`default_nettype none

interface alpn_sel_in_if
    import alpn_sel_pkg::*;
();
    logic  valid;
    logic  ready;
    byte_t ext_byte;
    logic  last_byte;

    modport source (output valid, output ext_byte, output last_byte, input ready);
    modport sink   (input valid, input ext_byte, input last_byte, output ready);
endinterface

interface alpn_sel_out_if
    import alpn_sel_pkg::*;
();
    logic    valid;
    logic    ready;
    choice_t choice;

    modport source (output valid, output choice, input ready);
    modport sink   (input valid, input choice, output ready);
endinterface

`default_nettype wire

// ===== src/alpn_list_selector_unit.sv =====
// Result: a request with last_byte set shows its choice in the cycle after acceptance.
// Throughput: one extension byte per cycle; each byte updates the scan state in one
// pass of comparators and 17-bit and 18-bit adders; while a choice waits to be taken the
// input is held off, and a request is taken again in the cycle the choice drains.
// Reset: rst_n is asynchronous, active low; it clears all scan state and the
// result valid; after each last byte the scan state returns to its reset value.
// alpn_list_selector_unit: top level, scans an ALPN protocol list byte by byte
// depends on alpn_sel_pkg and the channel interfaces in alpn_sel_if.sv
`default_nettype none

module alpn_list_selector_unit
    import alpn_sel_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    alpn_sel_in_if.sink    in_ch,
    alpn_sel_out_if.source out_ch
);

    // scan state
    logic [CNT_W-1:0] byte_count_reg, byte_count_next;
    logic [CNT_W-1:0] list_lim_reg, list_lim_next;
    logic [CNT_W-1:0] entry_end_reg, entry_end_next;
    logic [3:0]       name_pos_reg, name_pos_next;
    logic             in_name_reg, in_name_next;
    logic             h3_cand_reg, h3_cand_next;
    logic             hq_cand_reg, hq_cand_next;
    logic             found_h3_reg, found_h3_next;
    logic             found_hq_reg, found_hq_next;
    logic             stopped_reg, stopped_next;

    // result register
    logic    out_valid_reg;
    choice_t choice_reg, choice_next;

    logic       in_acc;
    logic [CNT_W:0] entry_end_wide;
    logic       h3_c, hq_c;

    // accept while the result slot is free or draining this cycle
    assign in_ch.ready   = !out_valid_reg || out_ch.ready;
    assign in_acc        = in_ch.valid && in_ch.ready;
    assign out_ch.valid  = out_valid_reg;
    assign out_ch.choice = choice_reg;

    // end offset of an entry whose length byte is at the current position
    assign entry_end_wide = {1'b0, byte_count_reg} + {{CNT_W{1'b0}}, 1'b1}
                          + {{(CNT_W-7){1'b0}}, in_ch.ext_byte};

    // per-byte scan update
    always_comb
    begin
        byte_count_next = byte_count_reg;
        list_lim_next   = list_lim_reg;
        entry_end_next  = entry_end_reg;
        name_pos_next   = name_pos_reg;
        in_name_next    = in_name_reg;
        h3_cand_next    = h3_cand_reg;
        hq_cand_next    = hq_cand_reg;
        found_h3_next   = found_h3_reg;
        found_hq_next   = found_hq_reg;
        stopped_next    = stopped_reg;
        choice_next     = CHOICE_NONE;
        h3_c            = 1'b0;
        hq_c            = 1'b0;

        if (byte_count_reg == '0)
        begin
            // high byte of the list length
            list_lim_next = {{(CNT_W-8){1'b0}}, in_ch.ext_byte};
        end
        else if (byte_count_reg == {{(CNT_W-1){1'b0}}, 1'b1})
        begin
            // list end offset is 2 plus the length
            list_lim_next = {{(CNT_W-16){1'b0}}, list_lim_reg[7:0], in_ch.ext_byte}
                          + {{(CNT_W-2){1'b0}}, 2'd2};
        end
        else if (byte_count_reg < list_lim_reg && !stopped_reg)
        begin
            if (!in_name_reg)
            begin
                // entry length byte
                if (entry_end_wide > {1'b0, list_lim_reg})
                begin
                    stopped_next = 1'b1;
                end
                else
                begin
                    entry_end_next = entry_end_wide[CNT_W-1:0];
                    if (in_ch.ext_byte != 8'd0)
                    begin
                        in_name_next  = 1'b1;
                        name_pos_next = 4'd0;
                        h3_cand_next  = (in_ch.ext_byte == {4'd0, H3_LEN});
                        hq_cand_next  = (in_ch.ext_byte == {4'd0, HQ_LEN});
                    end
                end
            end
            else
            begin
                // name byte: compare against both names
                h3_c = h3_cand_reg && (name_pos_reg < H3_LEN)
                    && (in_ch.ext_byte == h3_byte(name_pos_reg));
                hq_c = hq_cand_reg && (name_pos_reg < HQ_LEN)
                    && (in_ch.ext_byte == hq_byte(name_pos_reg));
                h3_cand_next  = h3_c;
                hq_cand_next  = hq_c;
                name_pos_next = name_pos_reg + 4'd1;
                if (entry_end_wide[CNT_W-1:0] - {{(CNT_W-8){1'b0}}, in_ch.ext_byte}
                    == entry_end_reg)
                begin
                    found_h3_next = found_h3_reg || h3_c;
                    found_hq_next = found_hq_reg || hq_c;
                    in_name_next  = 1'b0;
                end
            end
        end

        // saturating byte counter
        if (byte_count_reg != COUNT_MAX)
        begin
            byte_count_next = byte_count_reg + {{(CNT_W-1){1'b0}}, 1'b1};
        end

        // choice on the last byte, then back to reset state
        if (in_ch.last_byte)
        begin
            if (byte_count_next >= {{(CNT_W-2){1'b0}}, 2'd2}
                && list_lim_next <= byte_count_next)
            begin
                if (found_h3_next)
                begin
                    choice_next = CHOICE_H3;
                end
                else if (found_hq_next)
                begin
                    choice_next = CHOICE_HQ;
                end
            end
            byte_count_next = '0;
            list_lim_next   = '0;
            entry_end_next  = '0;
            name_pos_next   = 4'd0;
            in_name_next    = 1'b0;
            h3_cand_next    = 1'b0;
            hq_cand_next    = 1'b0;
            found_h3_next   = 1'b0;
            found_hq_next   = 1'b0;
            stopped_next    = 1'b0;
        end
    end

    // scan state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_count_reg <= '0;
            list_lim_reg   <= '0;
            entry_end_reg  <= '0;
            name_pos_reg   <= 4'd0;
            in_name_reg    <= 1'b0;
            h3_cand_reg    <= 1'b0;
            hq_cand_reg    <= 1'b0;
            found_h3_reg   <= 1'b0;
            found_hq_reg   <= 1'b0;
            stopped_reg    <= 1'b0;
        end
        else if (in_acc)
        begin
            byte_count_reg <= byte_count_next;
            list_lim_reg   <= list_lim_next;
            entry_end_reg  <= entry_end_next;
            name_pos_reg   <= name_pos_next;
            in_name_reg    <= in_name_next;
            h3_cand_reg    <= h3_cand_next;
            hq_cand_reg    <= hq_cand_next;
            found_h3_reg   <= found_h3_next;
            found_hq_reg   <= found_hq_next;
            stopped_reg    <= stopped_next;
        end
    end

    // result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_acc && in_ch.last_byte)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (in_acc && in_ch.last_byte)
        begin
            choice_reg <= choice_next;
        end
    end

    // a last byte always produces a result next cycle
    a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && in_ch.last_byte) |=> out_valid_reg)
        else $error("last byte accepted without a result");

    // scan state is cleared after a last byte
    a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && in_ch.last_byte) |=> (byte_count_reg == '0 && !in_name_reg
                                         && !found_h3_reg && !found_hq_reg))
        else $error("scan state not cleared after last byte");

    // a name is only open inside the list
    a_entry_in_list: assert property (@(posedge clk) disable iff (!rst_n)
        in_name_reg |-> (entry_end_reg <= list_lim_reg
                         && byte_count_reg > {{(CNT_W-2){1'b0}}, 2'd2}))
        else $error("open entry reaches past the list end");

    // a valid result carries a defined code
    a_choice_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (choice_reg == CHOICE_NONE || choice_reg == CHOICE_H3
                           || choice_reg == CHOICE_HQ))
        else $error("undefined choice code");

endmodule

`default_nettype wire
